>>> rtl/grr_pkg.sv
`default_nettype none
package grr_pkg;

	localparam int MAX_GROUP_DEF = 32;
	localparam int ADDR_W        = 20;
	localparam int VAL_W         = 32;
	localparam int GS_W          = 6;
	localparam int CMP_W         = GS_W + 1;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

	// Register index decoded from paddr[2]
	localparam logic REG_GROUP_SIZE = 1'b0;

	typedef struct packed {
		logic [ADDR_W-1:0]       node_addr;
		logic signed [VAL_W-1:0] node_value;
		logic                    is_final;
	} node_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       out_addr;
		logic signed [VAL_W-1:0] out_value;
		logic [ADDR_W-1:0]       next_addr;
		logic                    next_null;
		logic                    run_end;
	} node_out_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  value;
	} node_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic step;
		logic tail;
	} grr_cmd_t;

	typedef struct packed {
		logic close;
		logic held_valid;
		logic last;
		logic fin;
		logic out_free;
	} grr_sts_t;

endpackage
`default_nettype wire

>>> rtl/grr_ctrl.sv
`default_nettype none
module grr_ctrl
	import grr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire grr_sts_t st,
	output grr_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_PAIR,
		S_TAIL
	} state_t;

	state_t state_q;
	logic   go;

	assign in_ready = (state_q == S_IDLE);
	assign go       = !st.held_valid || st.out_free;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.wr   = in_valid;
			S_READ: cmd.rd   = 1'b1;
			S_PAIR: cmd.step = go;
			S_TAIL: cmd.tail = st.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && st.close)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_PAIR;
				S_PAIR: begin
					if (go) begin
						if (!st.last)
							state_q <= S_READ;
						else if (st.fin)
							state_q <= S_TAIL;
						else
							state_q <= S_IDLE;
					end
				end
				S_TAIL: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/grr_dp.sv
`default_nettype none
module grr_dp
	import grr_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [GS_W-1:0] group_size,
	input  wire node_in_t        in_data,
	input  wire grr_cmd_t        cmd,
	output grr_sts_t             st,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output node_out_t            out_data
);

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam logic [CMP_W-1:0] KMAX = CMP_W'(MAX_GROUP);

	node_t          mem_q [MAX_GROUP];
	node_t          rdata_q;
	node_t          held_q;
	logic           held_valid_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  remain_q;
	logic [AW-1:0]  ptr_q;
	logic           rev_q;
	logic           last_q;
	logic           fin_q;
	logic           out_valid_q;
	node_out_t      out_q;

	logic [CW-1:0]    fill_nxt;
	logic [CMP_W-1:0] gs_ext;
	logic [CMP_W-1:0] k_eff;
	logic             full;
	logic             out_free;

	assign fill_nxt = fill_q + CW'(1);
	assign gs_ext   = CMP_W'(group_size);
	assign k_eff    = (gs_ext == '0) ? CMP_W'(1) : ((gs_ext > KMAX) ? KMAX : gs_ext);
	assign full     = CMP_W'(fill_nxt) >= k_eff;
	assign out_free = !out_valid_q || out_ready;

	assign st.close      = full || in_data.is_final;
	assign st.held_valid = held_valid_q;
	assign st.last       = last_q;
	assign st.fin        = fin_q;
	assign st.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Group buffer
	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem_q[fill_q[AW-1:0]] <= '{addr: in_data.node_addr, value: in_data.node_value};
		if (cmd.rd)
			rdata_q <= mem_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			remain_q <= '0;
			ptr_q    <= '0;
			rev_q    <= 1'b0;
			last_q   <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			if (cmd.wr) begin
				if (full || in_data.is_final) begin
					// Close the group: full groups read backward, a final partial one forward
					fill_q   <= '0;
					remain_q <= fill_nxt;
					fin_q    <= in_data.is_final;
					rev_q    <= full;
					ptr_q    <= full ? fill_q[AW-1:0] : '0;
				end else begin
					fill_q <= fill_nxt;
				end
			end
			if (cmd.rd) begin
				remain_q <= remain_q - CW'(1);
				last_q   <= (remain_q == CW'(1));
				ptr_q    <= rev_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
			end
		end
	end

	// Held node and output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.step) begin
				held_valid_q <= 1'b1;
				if (held_valid_q)
					out_valid_q <= 1'b1;
				else if (out_ready)
					out_valid_q <= 1'b0;
			end else if (cmd.tail) begin
				held_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			held_q <= rdata_q;
			if (held_valid_q) begin
				out_q.out_addr  <= held_q.addr;
				out_q.out_value <= held_q.value;
				out_q.next_addr <= rdata_q.addr;
				out_q.next_null <= 1'b0;
				out_q.run_end   <= last_q && !fin_q;
			end
		end else if (cmd.tail) begin
			out_q.out_addr  <= held_q.addr;
			out_q.out_value <= held_q.value;
			out_q.next_addr <= '0;
			out_q.next_null <= 1'b1;
			out_q.run_end   <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/group_reverse_relink.sv
// Flow: an item that leaves its group open is simply written to the group buffer.
// An item that closes a group of m nodes starts a drain: one buffer read and one
// link step per node, plus a tail step for the list end on a final item; output
// stalls lengthen the drain. No new item is taken until the drain is done.
// Reset: arst_n clears the group fill, held node flag, output beat and state;
// group_size returns to 1.
`default_nettype none
module group_reverse_relink
	import grr_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire node_in_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output node_out_t               out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [GS_W-1:0] group_size_q;
	grr_cmd_t        cmd;
	grr_sts_t        st;
	logic            reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_GROUP_SIZE);
	assign prdata  = reg_hit ? PDATA_W'(group_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GS_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			group_size_q <= pwdata[GS_W-1:0];
		end
	end

	grr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	grr_dp #(
		.MAX_GROUP (MAX_GROUP)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.group_size (group_size_q),
		.in_data    (in_data),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// A null link always ends the beat run and carries a zero address
	a_null_link: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.next_null) |-> (out_data.run_end && out_data.next_addr == '0))
		else $error("null link beat malformed");

	// Hold a stalled output beat steady until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output beat changed while stalled");

	// A final item always starts a drain
	a_final_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.is_final) |=> !in_ready)
		else $error("final item did not start drain");

endmodule
`default_nettype wire
